// File: hdl/ksym_pkg.sv
// ksym_pkg: command and status codes and the entry layout of the keyed symbol table
// no dependencies
package ksym_pkg;

    localparam int KEY_W   = 64;
    localparam int TYPE_W  = 8;
    localparam int VALUE_W = 32;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 3;

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UPDATE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
    localparam logic [STAT_W-1:0] ST_EXISTS    = 3'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_W-1:0] ST_UNINIT    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

    typedef logic [CMD_W-1:0]   cmd_t;
    typedef logic [STAT_W-1:0]  stat_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [TYPE_W-1:0]  etype_t;
    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        key_t   key;
        etype_t etype;
        value_t value;
        logic   init;
    } entry_t;

    typedef struct packed {
        stat_t  status;
        value_t read_value;
        etype_t read_type;
    } result_t;

endpackage

// File: hdl/ksym_req_if.sv
// ksym_req_if: command channel with valid/ready handshake
// depends on ksym_pkg
interface ksym_req_if
    import ksym_pkg::*;
();
    logic   valid;
    logic   ready;
    cmd_t   command;
    key_t   key;
    etype_t entry_type;
    value_t new_value;

    modport source (output valid, output command, output key, output entry_type,
                    output new_value, input ready);
    modport sink   (input valid, input command, input key, input entry_type,
                    input new_value, output ready);
endinterface

// File: hdl/ksym_rsp_if.sv
// ksym_rsp_if: result channel with valid/ready handshake
// depends on ksym_pkg
interface ksym_rsp_if
    import ksym_pkg::*;
();
    logic   valid;
    logic   ready;
    stat_t  status;
    value_t read_value;
    etype_t read_type;

    modport source (output valid, output status, output read_value, output read_type,
                    input ready);
    modport sink   (input valid, input status, input read_value, input read_type,
                    output ready);
endinterface

// File: hdl/keyed_symbol_table.sv
// keyed_symbol_table: linear symbol table with insert, update, find and clear
// depends on ksym_pkg, ksym_req_if, ksym_rsp_if
// One command is taken at a time. Insert, update and find walk the valid entries from index
// 0 through the single read port of the entry memory, one entry per cycle, and stop at the
// first matching key. The result sits in an output register, so a new command is taken while
// a result still waits. Entries live in one memory of TABLE_DEPTH words holding key, type,
// value and initialized flag; no clearing pass is needed after reset.
module keyed_symbol_table
    import ksym_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)(
    input  logic      clk,
    input  logic      rst_n,
    ksym_req_if.sink  req,
    ksym_rsp_if.source rsp
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data;

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] addr_reg, addr_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic          chk_valid_reg, chk_valid_next;
    cmd_t          cmd_reg, cmd_next;
    key_t          key_reg, key_next;
    etype_t        etype_reg, etype_next;
    value_t        nval_reg, nval_next;
    result_t       res_reg, res_next;
    result_t       out_reg, out_next;
    logic          out_valid_reg, out_valid_next;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          we;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;
    logic          accept;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.read_value = out_reg.read_value;
    assign rsp.read_type  = out_reg.read_type;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        addr_next      = addr_reg;
        chk_idx_next   = chk_idx_reg;
        chk_valid_next = chk_valid_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        etype_next     = etype_reg;
        nval_next      = nval_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        rd_en          = 1'b0;
        rd_addr        = addr_reg[AW-1:0];
        we             = 1'b0;
        wr_addr        = chk_idx_reg;
        wr_data        = rd_data;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next       = req.command;
                    key_next       = req.key;
                    etype_next     = req.entry_type;
                    nval_next      = req.new_value;
                    addr_next      = '0;
                    chk_valid_next = 1'b0;
                    res_next       = '{status: ST_OK, read_value: '0, read_type: '0};
                    if (req.command == CMD_CLEAR)
                    begin
                        count_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (chk_valid_reg && rd_data.key == key_reg)
                begin
                    // first match at chk_idx_reg
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_INSERT: res_next.status = ST_EXISTS;
                        CMD_UPDATE:
                        begin
                            we            = 1'b1;
                            wr_addr       = chk_idx_reg;
                            wr_data       = rd_data;
                            wr_data.value = nval_reg;
                            wr_data.init  = 1'b1;
                        end
                        CMD_FIND:
                        begin
                            if (!rd_data.init)
                            begin
                                res_next.status = ST_UNINIT;
                            end
                            else
                            begin
                                res_next.read_value = rd_data.value;
                                res_next.read_type  = rd_data.etype;
                            end
                        end
                        default: res_next.status = ST_OK;
                    endcase
                end
                else if (addr_reg == count_reg)
                begin
                    // walked every valid entry without a match
                    state_next = S_DONE;
                    case (cmd_reg)
                        CMD_INSERT:
                        begin
                            if (count_reg == DEPTH_C)
                            begin
                                res_next.status = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                wr_addr    = count_reg[AW-1:0];
                                wr_data    = '{key: key_reg, etype: etype_reg,
                                               value: '0, init: 1'b0};
                                count_next = count_reg + CW'(1);
                            end
                        end
                        default: res_next.status = ST_NOT_FOUND;
                    endcase
                end
                else
                begin
                    rd_en          = 1'b1;
                    rd_addr        = addr_reg[AW-1:0];
                    chk_valid_next = 1'b1;
                    chk_idx_next   = addr_reg[AW-1:0];
                    addr_next      = addr_reg + CW'(1);
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            addr_reg      <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= chk_idx_next;
        cmd_reg     <= cmd_next;
        key_reg     <= key_next;
        etype_reg   <= etype_next;
        nval_reg    <= nval_next;
        res_reg     <= res_next;
        out_reg     <= out_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("entry count beyond table depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (addr_reg <= count_reg))
        else $error("scan address past entry count");

    assert property (@(posedge clk) disable iff (!rst_n)
        we |-> (state_reg == S_SCAN))
        else $error("memory write outside scan");

    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.command == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear did not empty the table");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != ST_OK) |->
        (out_reg.read_value == '0 && out_reg.read_type == '0))
        else $error("nonzero payload on failed command");

endmodule

// File: sim/ksym_checker.sv
// ksym_checker: watches the command and result channels of the keyed symbol table,
// predicts every result from its own copy of the table and compares in order
// depends on ksym_pkg, ksym_req_if, ksym_rsp_if
`timescale 1ns / 1ps

module ksym_checker
    import ksym_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)(
    input  logic clk,
    input  logic rst_n,
    ksym_req_if  req,
    ksym_rsp_if  rsp,
    output int   mismatches,
    output int   pending,
    output int   checked,
    output int   full_hits
);

    typedef struct {
        cmd_t    command;
        key_t    key;
        result_t outcome;
    } expected_t;

    key_t      sym_keys   [TABLE_DEPTH];
    etype_t    sym_types  [TABLE_DEPTH];
    value_t    sym_values [TABLE_DEPTH];
    bit        sym_init   [TABLE_DEPTH];
    int        live_entries;
    expected_t awaited_results[$];

    initial
    begin
        mismatches   = 0;
        pending      = 0;
        checked      = 0;
        full_hits    = 0;
        live_entries = 0;
    end

    function automatic int lookup_slot(key_t k);
        for (int i = 0; i < live_entries; i++)
        begin
            if (sym_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic result_t apply_command(cmd_t c, key_t k, etype_t t, value_t v);
        result_t r;
        int      slot;
        r    = '0;
        slot = lookup_slot(k);
        case (c)
            CMD_INSERT:
            begin
                if (slot >= 0)
                    r.status = ST_EXISTS;
                else if (live_entries >= TABLE_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    sym_keys[live_entries]   = k;
                    sym_types[live_entries]  = t;
                    sym_values[live_entries] = '0;
                    sym_init[live_entries]   = 1'b0;
                    live_entries++;
                end
            end
            CMD_UPDATE:
            begin
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    sym_values[slot] = v;
                    sym_init[slot]   = 1'b1;
                end
            end
            CMD_FIND:
            begin
                if (slot < 0)
                    r.status = ST_NOT_FOUND;
                else if (!sym_init[slot])
                    r.status = ST_UNINIT;
                else
                begin
                    r.read_value = sym_values[slot];
                    r.read_type  = sym_types[slot];
                end
            end
            default:
                live_entries = 0;
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        expected_t want;
        result_t   got;
        if (!rst_n)
        begin
            live_entries = 0;
            awaited_results.delete();
        end
        else
        begin
            // results first: a result can never belong to a command taken at the same edge
            if (rsp.valid && rsp.ready)
            begin
                got.status     = rsp.status;
                got.read_value = rsp.read_value;
                got.read_type  = rsp.read_type;
                if (awaited_results.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("[%0t] unexpected result: status %0d value %0d type %0d",
                                 $realtime, got.status, got.read_value, got.read_type);
                    mismatches++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    checked++;
                    if (got.status !== want.outcome.status ||
                        got.read_value !== want.outcome.read_value ||
                        got.read_type !== want.outcome.read_type)
                    begin
                        if (mismatches < 10)
                            $display({"[%0t] mismatch cmd %0d key %h: expected status %0d ",
                                      "value %0d type %0d, got status %0d value %0d type %0d"},
                                     $realtime, want.command, want.key,
                                     want.outcome.status, want.outcome.read_value,
                                     want.outcome.read_type, got.status, got.read_value,
                                     got.read_type);
                        mismatches++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                want.command = req.command;
                want.key     = req.key;
                want.outcome = apply_command(req.command, req.key, req.entry_type,
                                             req.new_value);
                if (want.outcome.status == ST_FULL)
                    full_hits++;
                awaited_results.push_back(want);
            end
        end
        pending = awaited_results.size();
    end

endmodule

// File: sim/tb.sv
// tb: stimulus and verdict for the keyed symbol table, with bursty commands, a stalling
// result side and one long result hold-off; checking is done by ksym_checker
// depends on ksym_pkg, ksym_req_if, ksym_rsp_if, keyed_symbol_table, ksym_checker
`timescale 1ns / 1ps

module tb;
    import ksym_pkg::*;

    localparam int TABLE_DEPTH = 64;
    localparam int ITEMS       = 1900;
    localparam int IDLE_LIMIT  = 5000;
    localparam int LONG_HOLD   = 400;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ksym_req_if req_ch ();
    ksym_rsp_if rsp_ch ();

    int   chk_mismatches;
    int   chk_pending;
    int   chk_checked;
    int   chk_full_hits;
    int   issued;
    int   cmd_count [4];
    int   burst_left;
    int   idle_cycles;
    key_t pool[$];

    keyed_symbol_table #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    ksym_checker #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .mismatches (chk_mismatches),
        .pending    (chk_pending),
        .checked    (chk_checked),
        .full_hits  (chk_full_hits)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[%0t] no transfer for %0d cycles", $realtime, IDLE_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result side: stall modes that change every so often, plus one long hold-off
    initial
    begin : receiver
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  long_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        long_done = 1'b0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_left > 0)
            begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (!long_done && issued >= 300)
            begin
                long_done = 1'b1;
                hold_left = LONG_HOLD - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 200);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= ($urandom_range(0, 1) == 0);
                    2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ch.ready <= (mode_left % 6) < 3;
                endcase
            end
        end
    end

    task automatic issue(cmd_t c, key_t k, etype_t t, value_t v);
        int gap;
        int r;
        req_ch.valid      <= 1'b1;
        req_ch.command    <= c;
        req_ch.key        <= k;
        req_ch.entry_type <= t;
        req_ch.new_value  <= v;
        do
            @(posedge clk);
        while (!req_ch.ready);
        issued++;
        cmd_count[c]++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            r = $urandom_range(0, 9);
            if (r < 6)
                gap = $urandom_range(1, 4);
            else if (r < 8)
                gap = $urandom_range(5, 20);
            else if (r == 8)
                gap = $urandom_range(30, 80);
            else
                gap = 0;
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
        end
    endtask

    function automatic key_t fresh_key();
        key_t k;
        k = {$urandom, $urandom};
        if (pool.size() > 0 && $urandom_range(0, 7) == 0)
        begin
            // neighbor of a stored key, one bit apart
            k = pool[$urandom_range(0, pool.size() - 1)];
            k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
        end
        else if ($urandom_range(0, 15) == 0)
            k = k & 64'h0000_00FF_FFFF_FFFF;
        return k;
    endfunction

    function automatic key_t pick_key();
        if (pool.size() > 0 && $urandom_range(0, 4) != 0)
            return pool[$urandom_range(0, pool.size() - 1)];
        return fresh_key();
    endfunction

    task automatic random_op(int clear_pct);
        int   r;
        cmd_t c;
        r = $urandom_range(0, 99);
        if (r < clear_pct)
            c = CMD_CLEAR;
        else if (r < 35)
            c = CMD_INSERT;
        else if (r < 65)
            c = CMD_UPDATE;
        else
            c = CMD_FIND;
        issue(c, pick_key(), etype_t'($urandom), value_t'($urandom));
    endtask

    initial
    begin : stimulus
        int   kind;
        int   target;
        int   added;
        key_t k;
        burst_left  = 0;
        issued      = 0;
        foreach (cmd_count[i])
            cmd_count[i] = 0;
        req_ch.valid      <= 1'b0;
        req_ch.command    <= CMD_FIND;
        req_ch.key        <= '0;
        req_ch.entry_type <= '0;
        req_ch.new_value  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty table, duplicates, uninitialized entries, value extremes
        issue(CMD_CLEAR,  '0,                    8'h00, '0);
        issue(CMD_FIND,   '0,                    8'h00, '0);
        issue(CMD_UPDATE, '0,                    8'h00, value_t'(32'h1234_5678));
        issue(CMD_INSERT, '0,                    8'h00, value_t'(32'hFFFF_FFFF));
        issue(CMD_INSERT, '1,                    8'hFF, '0);
        issue(CMD_INSERT, '0,                    8'h07, '0);
        issue(CMD_FIND,   '0,                    8'h00, '0);
        issue(CMD_UPDATE, '0,                    8'h00, value_t'(32'h8000_0000));
        issue(CMD_FIND,   '0,                    8'h00, '0);
        issue(CMD_UPDATE, '1,                    8'h00, value_t'(32'h7FFF_FFFF));
        issue(CMD_FIND,   '1,                    8'hFF, '0);
        issue(CMD_UPDATE, '0,                    8'h00, value_t'(32'hFFFF_FFFF));
        issue(CMD_FIND,   '0,                    8'h00, '0);
        issue(CMD_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 8'h55, '0);
        issue(CMD_UPDATE, 64'hAAAA_AAAA_AAAA_AAAA, 8'h00, '0);
        issue(CMD_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 8'h00, '0);
        issue(CMD_INSERT, 64'h5555_5555_5555_5555, 8'hAA, '0);
        issue(CMD_FIND,   64'h5555_5555_5555_5555, 8'h00, '0);
        issue(CMD_FIND,   64'h0000_0000_0000_0001, 8'h00, '0);
        issue(CMD_UPDATE, 64'h8000_0000_0000_0000, 8'h00, '0);
        issue(CMD_CLEAR,  '1,                    8'hFF, '1);
        issue(CMD_FIND,   '0,                    8'h00, '0);
        issue(CMD_INSERT, '0,                    8'h3C, '0);
        issue(CMD_FIND,   '0,                    8'h00, '0);

        // random episodes: fill to capacity, small busy tables, and noise
        while (issued < ITEMS)
        begin
            kind = $urandom_range(0, 9);
            pool.delete();
            if (kind < 4)
            begin
                issue(CMD_CLEAR, {$urandom, $urandom}, etype_t'($urandom), value_t'($urandom));
                target = $urandom_range(TABLE_DEPTH - 4, TABLE_DEPTH + 6);
                added  = 0;
                while (added < target)
                begin
                    if (pool.size() > 0 && $urandom_range(0, 3) == 0)
                        random_op(0);
                    else
                    begin
                        k = fresh_key();
                        pool.push_back(k);
                        added++;
                        issue(CMD_INSERT, k, etype_t'($urandom), value_t'($urandom));
                    end
                end
                repeat ($urandom_range(10, 30)) random_op(3);
            end
            else if (kind < 9)
            begin
                if ($urandom_range(0, 1) == 0)
                    issue(CMD_CLEAR, pick_key(), etype_t'($urandom), value_t'($urandom));
                repeat ($urandom_range(1, 12)) pool.push_back(fresh_key());
                repeat ($urandom_range(20, 60)) random_op(4);
            end
            else
            begin
                repeat ($urandom_range(10, 30))
                    issue(cmd_t'($urandom_range(0, 3)), {$urandom, $urandom},
                          etype_t'($urandom), value_t'($urandom));
            end
        end

        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (chk_pending == 0);
        repeat (TABLE_DEPTH + 8) @(posedge clk);

        $display("%0d commands: %0d insert, %0d update, %0d find, %0d clear; %0d results checked",
                 issued, cmd_count[CMD_INSERT], cmd_count[CMD_UPDATE], cmd_count[CMD_FIND],
                 cmd_count[CMD_CLEAR], chk_checked);
        $display("%0d inserts rejected on a full table, one %0d-cycle result hold-off, %0d errors",
                 chk_full_hits, LONG_HOLD, chk_mismatches);
        if (chk_mismatches == 0 && chk_pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
